/* rtl/ack_interval_window_controller_macros.svh */
// ============================================================================
// ack_interval_window_controller_macros.svh - assertion macros
// Shared assertion forms used by the checker of the window controller.
// ============================================================================
`ifndef ACK_INTERVAL_WINDOW_CONTROLLER_MACROS_SVH
`define ACK_INTERVAL_WINDOW_CONTROLLER_MACROS_SVH

// Next-cycle implication that is switched off while reset is held.
`define AIWC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("window controller assertion failed");

// Next-cycle implication that is checked through reset as well.
`define AIWC_ASSERT_NEXT_ALWAYS(lbl, clk_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error("window controller reset assertion failed");

`endif

/* rtl/aiwc_pkg.sv */
// ============================================================================
// aiwc_pkg - shared definitions of the ack interval window controller
// Widths, register indexes, reset values and sequencer states.
// ============================================================================
package aiwc_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int COUNT_BITS    = 16;

  // Field widths.
  localparam int OP_W       = 1;
  localparam int RX_W       = 32;
  localparam int TIME_W     = 10;
  localparam int WIN_W      = 8;
  localparam int INIT_W     = 16;
  localparam int INTERVAL_W = 16;
  localparam int OUT_CNT_W  = 16;
  localparam int OUT_EST_W  = 24;
  localparam int DRAIN_W    = 16;

  // Derived datapath widths.
  localparam int EWMA_W  = INIT_W + FRACTION_BITS;
  localparam int SHIFT_W = TIME_W + FRACTION_BITS + 1;
  localparam int NUM_W   = ((SHIFT_W > EWMA_W) ? SHIFT_W : EWMA_W) + 1;
  localparam int DEN_W   = EWMA_W + 1;
  localparam int ITER_W  = $clog2(NUM_W);
  localparam int CMP_W   = (COUNT_BITS > DRAIN_W) ? COUNT_BITS : DRAIN_W;

  // Configuration port.
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TIME_WINDOW  = 3'd0,
    REG_MAX_WINDOW   = 3'd1,
    REG_MIN_WINDOW   = 3'd2,
    REG_TRICKLE      = 3'd3,
    REG_INIT_INTERVAL = 3'd4
  } reg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [TIME_W-1:0] TIME_WINDOW_RST   = 10'd80;
  localparam logic [WIN_W-1:0]  MAX_WINDOW_RST    = 8'd50;
  localparam logic [WIN_W-1:0]  MIN_WINDOW_RST    = 8'd5;
  localparam logic [WIN_W-1:0]  TRICKLE_RST       = 8'd3;
  localparam logic [INIT_W-1:0] INIT_INTERVAL_RST = 16'd20;

  // Event kinds.
  localparam logic OP_SEND = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

/* rtl/ack_interval_window_controller.sv */
// ============================================================================
// ack_interval_window_controller - sender-side congestion window engine
// Tracks outstanding packets and a smoothed ack inter-arrival interval, and
// reports the allowed window after every send or ack event.
// ============================================================================
//
//  channel   direction  handshake                      payload
//  event     in         event_valid / event_ready      operation, receive_time_ms
//  result    out        result_valid / result_ready    window_packets,
//                                                      outstanding_count,
//                                                      interval_estimate
//  config    in         APB psel / penable / pready    paddr, pwdata, prdata
//
// Each event passes through the sequencer steps in order: the state update on
// acceptance, the load of the divider, the restoring divider that forms the
// drain estimate, and the window compare and clamp. A zero average skips the
// divider. event_ready is high only while the sequencer is idle. A result
// waiting on result_ready holds the sequencer in its final step, so a stalled
// output blocks new events. Reset is synchronous and needs no clearing pass.
// ============================================================================
module ack_interval_window_controller (
  input  logic                            clk,
  input  logic                            rst,
  // Event channel.
  input  logic                            event_valid,
  output logic                            event_ready,
  input  logic [aiwc_pkg::OP_W-1:0]       operation,
  input  logic [aiwc_pkg::RX_W-1:0]       receive_time_ms,
  // Result channel.
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [aiwc_pkg::WIN_W-1:0]      window_packets,
  output logic [aiwc_pkg::OUT_CNT_W-1:0]  outstanding_count,
  output logic [aiwc_pkg::OUT_EST_W-1:0]  interval_estimate,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [aiwc_pkg::ADDR_W-1:0]     paddr,
  input  logic [aiwc_pkg::DATA_W-1:0]     pwdata,
  output logic [aiwc_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);

  import aiwc_pkg::*;

  // Configuration registers.
  logic [TIME_W-1:0] time_window_ms;
  logic [WIN_W-1:0]  max_window;
  logic [WIN_W-1:0]  min_window;
  logic [WIN_W-1:0]  trickle_window;
  logic [INIT_W-1:0] initial_interval_ms;

  // Block state.
  logic [EWMA_W-1:0]     ewma;
  logic [COUNT_BITS-1:0] in_flight;
  logic [RX_W-1:0]       prev_time;
  logic                  first_ack;

  // Sequencer and divider.
  state_t             state;
  state_t             state_next;
  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   rem;
  logic [ITER_W-1:0]  iter;
  logic [DRAIN_W-1:0] drain;

  logic event_fire;
  logic cfg_write;
  logic out_free;
  reg_idx_t reg_idx;

  assign pready     = 1'b1;
  assign reg_idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_write  = psel && penable && pwrite && pready;
  assign event_fire = event_valid && event_ready;
  assign out_free   = !result_valid || result_ready;

  // ---------------------------------------------------------------------------
  // Register readback.
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (reg_idx)
      REG_TIME_WINDOW:   prdata = DATA_W'(time_window_ms);
      REG_MAX_WINDOW:    prdata = DATA_W'(max_window);
      REG_MIN_WINDOW:    prdata = DATA_W'(min_window);
      REG_TRICKLE:       prdata = DATA_W'(trickle_window);
      REG_INIT_INTERVAL: prdata = DATA_W'(initial_interval_ms);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Event update. The interval between receiver timestamps wraps modulo 2^32
  // and saturates to 16 bits; the first ack counts as a zero interval. The
  // average takes a quarter of the new sample, rounded to nearest.
  // ---------------------------------------------------------------------------
  logic [RX_W-1:0]       rx_delta;
  logic [INTERVAL_W-1:0] interval;
  logic [EWMA_W+2:0]     ewma_sum;
  logic [EWMA_W-1:0]     ewma_upd;

  always_comb begin
    rx_delta = receive_time_ms - prev_time;
    if (first_ack) begin
      interval = '0;
    end else if (|rx_delta[RX_W-1:INTERVAL_W]) begin
      interval = '1;
    end else begin
      interval = rx_delta[INTERVAL_W-1:0];
    end
    ewma_sum = (EWMA_W+3)'(ewma) + (EWMA_W+3)'({ewma, 1'b0})
             + (EWMA_W+3)'({interval, FRACTION_BITS'(0)}) + (EWMA_W+3)'(2);
    ewma_upd = ewma_sum[EWMA_W+1:2];
  end

  // ---------------------------------------------------------------------------
  // Divider step: one restoring quotient bit per cycle. The quotient shifts
  // into num from the bottom as the numerator shifts out at the top.
  // ---------------------------------------------------------------------------
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_diff;
  logic             q_bit;
  logic [NUM_W-1:0] quot_final;
  logic [DRAIN_W-1:0] quot_sat;

  always_comb begin
    trial      = {rem, num[NUM_W-1]};
    trial_diff = trial - {1'b0, den};
    q_bit      = (trial >= {1'b0, den});
    quot_final = {num[NUM_W-2:0], q_bit};
    if (|quot_final[NUM_W-1:DRAIN_W]) begin
      quot_sat = '1;
    end else begin
      quot_sat = quot_final[DRAIN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Window decision. Trickle when the outstanding count exceeds the drain
  // estimate, else the leftover, with the minimum test taking precedence.
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] flight_x;
  logic [CMP_W-1:0] drain_x;
  logic [CMP_W-1:0] left;
  logic [WIN_W-1:0] window_calc;

  always_comb begin
    flight_x = CMP_W'(in_flight);
    drain_x  = CMP_W'(drain);
    left     = drain_x - flight_x;
    if (flight_x > drain_x) begin
      window_calc = trickle_window;
    end else if (left < CMP_W'(min_window)) begin
      window_calc = min_window;
    end else if (left > CMP_W'(max_window)) begin
      window_calc = max_window;
    end else begin
      window_calc = left[WIN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    event_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        event_ready = 1'b1;
        if (event_valid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // A zero average has no finite ratio; the estimate saturates.
        if (ewma == '0) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (iter == '0) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Configuration and block state. Writes must arrive only while idle, so they
  // never race an event update of the average; the block does not enforce this.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      time_window_ms      <= TIME_WINDOW_RST;
      max_window          <= MAX_WINDOW_RST;
      min_window          <= MIN_WINDOW_RST;
      trickle_window      <= TRICKLE_RST;
      initial_interval_ms <= INIT_INTERVAL_RST;
      ewma                <= {INIT_INTERVAL_RST, FRACTION_BITS'(0)};
      in_flight           <= '0;
      prev_time           <= '0;
      first_ack           <= 1'b1;
    end else begin
      if (cfg_write) begin
        unique case (reg_idx)
          REG_TIME_WINDOW:   time_window_ms <= pwdata[TIME_W-1:0];
          REG_MAX_WINDOW:    max_window     <= pwdata[WIN_W-1:0];
          REG_MIN_WINDOW:    min_window     <= pwdata[WIN_W-1:0];
          REG_TRICKLE:       trickle_window <= pwdata[WIN_W-1:0];
          REG_INIT_INTERVAL: begin
            initial_interval_ms <= pwdata[INIT_W-1:0];
            ewma                <= {pwdata[INIT_W-1:0], FRACTION_BITS'(0)};
          end
          default: ;
        endcase
      end
      if (event_fire) begin
        if (operation == OP_SEND) begin
          if (in_flight != '1) begin
            in_flight <= in_flight + COUNT_BITS'(1);
          end
        end else begin
          if (in_flight != '0) begin
            in_flight <= in_flight - COUNT_BITS'(1);
          end
          ewma      <= ewma_upd;
          prev_time <= receive_time_ms;
          first_ack <= 1'b0;
        end
      end
    end
  end

  // Divider datapath: round(time_window / ewma) as
  // (time_window * 2^(F+1) + ewma) / (2 * ewma).
  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: begin
        num  <= NUM_W'({time_window_ms, (FRACTION_BITS+1)'(0)}) + NUM_W'(ewma);
        den  <= {ewma, 1'b0};
        rem  <= '0;
        iter <= ITER_W'(NUM_W - 1);
        if (ewma == '0) begin
          drain <= '1;
        end
      end
      ST_DIVIDE: begin
        num  <= quot_final;
        rem  <= q_bit ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
        iter <= iter - ITER_W'(1);
        if (iter == '0) begin
          drain <= quot_sat;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register. It parts the result channel from the sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      window_packets    <= window_calc;
      outstanding_count <= OUT_CNT_W'(in_flight);
      interval_estimate <= OUT_EST_W'(ewma);
    end
  end

endmodule

/* rtl/aiwc_checker.sv */
// ============================================================================
// aiwc_checker - port-level assertions for the window controller
// Watches the top-level ports over time and is bound to the top level.
// ============================================================================
`include "ack_interval_window_controller_macros.svh"

module aiwc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            event_valid,
  input logic                            event_ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input logic [aiwc_pkg::WIN_W-1:0]      window_packets,
  input logic [aiwc_pkg::OUT_CNT_W-1:0]  outstanding_count,
  input logic [aiwc_pkg::OUT_EST_W-1:0]  interval_estimate
);

  // After reset the block is idle with no result pending.
  `AIWC_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, event_ready && !result_valid)

  // An accepted event occupies the sequencer for the following cycle.
  `AIWC_ASSERT_NEXT(a_busy_after_accept, clk, rst, event_valid && event_ready, !event_ready)

  // A stalled result beat holds its payload.
  `AIWC_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(window_packets) && $stable(outstanding_count) && $stable(interval_estimate))

endmodule

bind ack_interval_window_controller aiwc_checker u_aiwc_checker (.*);
